/* hw/rtl/dca_pkg.sv */
// Shared constants and helpers of the calendar date arithmetic core.
package dca_pkg;

  localparam int FIRST_YEAR        = 2000;
  localparam int YEAR_SPAN_DEFAULT = 256;

  // Field widths of the input and result beats.
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 16;
  localparam int DIFF_W  = 18;

  // Command codes.
  localparam logic CMD_DIFF = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  // Length of a month in days; unused codes read as 31.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic              leap);
    logic [DAY_W-1:0] len;
    begin
      case (m) inside
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
        MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
        default: len = DAY_W'(31);
      endcase
      return len;
    end
  endfunction

endpackage

/* hw/rtl/dca_if.sv */
// Request and response channel interfaces of the calendar date arithmetic core.
interface dca_req_if;
  import dca_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [YEAR_W-1:0]    year_a;
  logic [MONTH_W-1:0]   month_a;
  logic [DAY_W-1:0]     day_a;
  logic [YEAR_W-1:0]    year_b;
  logic [MONTH_W-1:0]   month_b;
  logic [DAY_W-1:0]     day_b;
  logic [COUNT_W-1:0]   add_count;

  modport source (output valid, cmd, year_a, month_a, day_a, year_b, month_b, day_b,
                  add_count, input ready);
  modport sink (input valid, cmd, year_a, month_a, day_a, year_b, month_b, day_b,
                add_count, output ready);
endinterface

interface dca_rsp_if;
  import dca_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DIFF_W-1:0]  diff_days;
  logic [YEAR_W-1:0]         out_year;
  logic [MONTH_W-1:0]        out_month;
  logic [DAY_W-1:0]          out_day;
  logic                      overflow;

  modport source (output valid, diff_days, out_year, out_month, out_day, overflow,
                  input ready);
  modport sink (input valid, diff_days, out_year, out_month, out_day, overflow,
                output ready);
endinterface

/* hw/rtl/calendar_date_arithmetic_core.sv */
// Gregorian date difference and add-days core built around one shared adder.
// Command 0 walks dates A and B to day numbers; command 1 walks A, adds the count, then
//   splits the sum back into a date; the result register is loaded last.
// One beat at a time: a new request is taken only in idle; the single adder steps
//   one year or one month per cycle.
// Reset: asynchronous active low; clears the sequencer and the result valid.
module calendar_date_arithmetic_core #(
  parameter int YEAR_SPAN = dca_pkg::YEAR_SPAN_DEFAULT
) (
  input logic       clk_i,
  input logic       rst_ni,
  dca_req_if.sink   req_i,
  dca_rsp_if.source rsp_o
);
  import dca_pkg::*;

  localparam int LAST_YEAR = FIRST_YEAR + YEAR_SPAN - 1;
  localparam int LEAPS     = (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
                           - (1999 / 4 - 1999 / 100 + 1999 / 400);
  localparam int TOTAL     = YEAR_SPAN * 365 + LEAPS - 1;
  localparam int YW_RAW    = $clog2(LAST_YEAR + 1);
  localparam int YW        = (YW_RAW > YEAR_W) ? YW_RAW : YEAR_W;
  localparam int DN_W      = $clog2(TOTAL + (2 ** COUNT_W) + 1);
  localparam int DX_W      = (DN_W + 1 > DIFF_W) ? DN_W + 1 : DIFF_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_YEAR = 3'd1;
  localparam logic [2:0] ST_DAY  = 3'd2;
  localparam logic [2:0] ST_MON  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_DYR  = 3'd5;
  localparam logic [2:0] ST_DMO  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]          state_q, state_d;
  logic                side_q, side_d;
  logic                cmd_q, cmd_d;
  logic [YW-1:0]       ya_q, ya_d, yb_q, yb_d;
  logic [MONTH_W-1:0]  ma_q, ma_d, mb_q, mb_d;
  logic [DAY_W-1:0]    da_q, da_d, db_q, db_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [YW-1:0]       y_q, y_d;
  logic [MONTH_W-1:0]  m_q, m_d;
  logic [6:0]          c100_q, c100_d;
  logic [8:0]          c400_q, c400_d;
  logic [DN_W-1:0]     acc_q, acc_d;
  logic [DN_W-1:0]     na_q, na_d;
  logic                ovf_q, ovf_d;
  logic                ov_q, ov_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic [YEAR_W-1:0]   oy_q, oy_d;
  logic [MONTH_W-1:0]  om_q, om_d;
  logic [DAY_W-1:0]    od_q, od_d;
  logic                oo_q, oo_d;

  logic                leap;
  logic [8:0]          year_len;
  logic [YW-1:0]       tgt_year;
  logic [MONTH_W-1:0]  tgt_month;
  logic [DAY_W-1:0]    cur_day;
  logic [DAY_W-1:0]    cur_len;
  logic                alu_sub;
  logic [DN_W-1:0]     alu_op;
  logic [DN_W:0]       alu_res;
  logic                alu_ge;
  logic [YW-1:0]       ya_in, yb_in, ya_clamp, yb_clamp;
  logic [DX_W-1:0]     diff_wide;
  logic                accept;

  // Leap year from the running mod-100 and mod-400 counters; 2000 is a multiple of 4.
  assign leap     = (c400_q == 9'd0) || ((c100_q != 7'd0) && (y_q[1:0] == 2'b00));
  assign year_len = leap ? 9'd366 : 9'd365;
  assign tgt_year  = side_q ? yb_q : ya_q;
  assign tgt_month = side_q ? mb_q : ma_q;
  assign cur_day   = side_q ? db_q : da_q;
  assign cur_len   = month_len(m_q, leap);

  // Year clamp of the incoming dates.
  assign ya_in    = YW'(req_i.year_a);
  assign yb_in    = YW'(req_i.year_b);
  assign ya_clamp = (ya_in < YW'(FIRST_YEAR)) ? YW'(FIRST_YEAR) :
                    (ya_in > YW'(LAST_YEAR))  ? YW'(LAST_YEAR)  : ya_in;
  assign yb_clamp = (yb_in < YW'(FIRST_YEAR)) ? YW'(FIRST_YEAR) :
                    (yb_in > YW'(LAST_YEAR))  ? YW'(LAST_YEAR)  : yb_in;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Operand selection of the shared add/subtract unit.
  always_comb begin
    alu_sub = 1'b0;
    alu_op  = '0;
    case (state_q)
      ST_YEAR: alu_op = DN_W'(year_len);
      ST_MON:  alu_op = (m_q != tgt_month) ? DN_W'(cur_len) : DN_W'(cur_day - DAY_W'(1));
      ST_ADD:  alu_op = DN_W'(cnt_q);
      ST_DYR: begin
        alu_sub = 1'b1;
        alu_op  = DN_W'(year_len);
      end
      ST_DMO: begin
        alu_sub = 1'b1;
        alu_op  = DN_W'(cur_len);
      end
      default: alu_op = '0;
    endcase
  end

  // Shared adder; in subtract mode the carry out means acc >= operand.
  assign alu_res = {1'b0, acc_q} + {1'b0, (alu_sub ? ~alu_op : alu_op)} + (DN_W + 1)'(alu_sub);
  assign alu_ge  = alu_res[DN_W];

  assign diff_wide = DX_W'(na_q) - DX_W'(acc_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    cmd_d   = cmd_q;
    ya_d    = ya_q;
    ma_d    = ma_q;
    da_d    = da_q;
    yb_d    = yb_q;
    mb_d    = mb_q;
    db_d    = db_q;
    cnt_d   = cnt_q;
    y_d     = y_q;
    m_d     = m_q;
    c100_d  = c100_q;
    c400_d  = c400_q;
    acc_d   = acc_q;
    na_d    = na_q;
    ovf_d   = ovf_q;
    ov_d    = ov_q;
    diff_d  = diff_q;
    oy_d    = oy_q;
    om_d    = om_q;
    od_d    = od_q;
    oo_d    = oo_q;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = req_i.cmd;
          ya_d    = ya_clamp;
          yb_d    = yb_clamp;
          ma_d    = ((req_i.month_a == '0) || (req_i.month_a > MONTH_DEC)) ? MONTH_JAN
                                                                          : req_i.month_a;
          mb_d    = ((req_i.month_b == '0) || (req_i.month_b > MONTH_DEC)) ? MONTH_JAN
                                                                          : req_i.month_b;
          da_d    = req_i.day_a;
          db_d    = req_i.day_b;
          cnt_d   = req_i.add_count;
          side_d  = 1'b0;
          y_d     = YW'(FIRST_YEAR);
          c100_d  = '0;
          c400_d  = '0;
          acc_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_YEAR;
        end
      end
      // Accumulate whole years up to the target year.
      ST_YEAR: begin
        if (y_q != tgt_year) begin
          acc_d  = alu_res[DN_W-1:0];
          y_d    = y_q + YW'(1);
          c100_d = (c100_q == 7'd99)  ? 7'd0 : c100_q + 7'd1;
          c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        end else begin
          state_d = ST_DAY;
        end
      end
      // Clamp the day now that the leap flag of the target year is known.
      ST_DAY: begin
        m_d     = MONTH_JAN;
        state_d = ST_MON;
        if ((cur_day == '0) || (cur_day > month_len(tgt_month, leap))) begin
          if (side_q) db_d = DAY_W'(1);
          else        da_d = DAY_W'(1);
        end
      end
      // Accumulate whole months, then the day of the month.
      ST_MON: begin
        acc_d = alu_res[DN_W-1:0];
        if (m_q != tgt_month) begin
          m_d = m_q + MONTH_W'(1);
        end else if (side_q) begin
          state_d = ST_DONE;
        end else begin
          na_d = alu_res[DN_W-1:0];
          if (cmd_q == CMD_DIFF) begin
            side_d  = 1'b1;
            y_d     = YW'(FIRST_YEAR);
            c100_d  = '0;
            c400_d  = '0;
            acc_d   = '0;
            state_d = ST_YEAR;
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      // Add the day count and saturate at the last supported day.
      ST_ADD: begin
        if (alu_res > (DN_W + 1)'(TOTAL)) begin
          acc_d = DN_W'(TOTAL);
          ovf_d = 1'b1;
        end else begin
          acc_d = alu_res[DN_W-1:0];
        end
        y_d     = YW'(FIRST_YEAR);
        m_d     = MONTH_JAN;
        c100_d  = '0;
        c400_d  = '0;
        state_d = ST_DYR;
      end
      // Split the day number back into years.
      ST_DYR: begin
        if (alu_ge) begin
          acc_d  = alu_res[DN_W-1:0];
          y_d    = y_q + YW'(1);
          c100_d = (c100_q == 7'd99)  ? 7'd0 : c100_q + 7'd1;
          c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        end else begin
          state_d = ST_DMO;
        end
      end
      // Then into months; December takes the rest.
      ST_DMO: begin
        if (alu_ge && (m_q != MONTH_DEC)) begin
          acc_d = alu_res[DN_W-1:0];
          m_d   = m_q + MONTH_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      // Load the result register once it is free.
      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          state_d = ST_IDLE;
          if (cmd_q == CMD_DIFF) begin
            diff_d = DIFF_W'(diff_wide);
            oy_d   = ya_q[YEAR_W-1:0];
            om_d   = ma_q;
            od_d   = da_q;
            oo_d   = 1'b0;
          end else begin
            diff_d = '0;
            oy_d   = y_q[YEAR_W-1:0];
            om_d   = m_q;
            od_d   = acc_q[DAY_W-1:0] + DAY_W'(1);
            oo_d   = ovf_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    cmd_q  <= cmd_d;
    ya_q   <= ya_d;
    ma_q   <= ma_d;
    da_q   <= da_d;
    yb_q   <= yb_d;
    mb_q   <= mb_d;
    db_q   <= db_d;
    cnt_q  <= cnt_d;
    y_q    <= y_d;
    m_q    <= m_d;
    c100_q <= c100_d;
    c400_q <= c400_d;
    acc_q  <= acc_d;
    na_q   <= na_d;
    ovf_q  <= ovf_d;
    diff_q <= diff_d;
    oy_q   <= oy_d;
    om_q   <= om_d;
    od_q   <= od_d;
    oo_q   <= oo_d;
  end

  assign rsp_o.valid     = ov_q;
  assign rsp_o.diff_days = diff_q;
  assign rsp_o.out_year  = oy_q;
  assign rsp_o.out_month = om_q;
  assign rsp_o.out_day   = od_q;
  assign rsp_o.overflow  = oo_q;

  // An accepted beat always starts a year walk.
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_YEAR))
    else $error("accepted beat did not start the year walk");

  // A new result only appears out of the done state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ($past(state_q) == ST_DONE))
    else $error("result valid rose outside the done state");

  // Overflowed sums carry no day difference.
  a_ovf_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oo_q) |-> (diff_q == '0))
    else $error("overflow flagged with a nonzero difference");

  // Result month is always a calendar month.
  a_month_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> ((om_q >= MONTH_JAN) && (om_q <= MONTH_DEC)))
    else $error("result month out of range");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the calendar date arithmetic core: directed and random date beats.
module tb;
  import dca_pkg::*;

  localparam int YEAR_SPAN        = YEAR_SPAN_DEFAULT;
  localparam int LAST_YEAR        = FIRST_YEAR + YEAR_SPAN - 1;
  localparam int RANDOM_PER_PHASE = 185;
  localparam int PRESSURE_HOLD    = 1500;
  localparam int WATCHDOG_LIMIT   = 6000;
  localparam int DRAIN_CYCLES     = 2 * YEAR_SPAN + 100;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic               cmd;
    logic [YEAR_W-1:0]  year_a;
    logic [MONTH_W-1:0] month_a;
    logic [DAY_W-1:0]   day_a;
    logic [YEAR_W-1:0]  year_b;
    logic [MONTH_W-1:0] month_b;
    logic [DAY_W-1:0]   day_b;
    logic [COUNT_W-1:0] add_count;
  } date_req_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_days;
    logic [YEAR_W-1:0]        out_year;
    logic [MONTH_W-1:0]       out_month;
    logic [DAY_W-1:0]         out_day;
    logic                     overflow;
  } date_rsp_t;

  // Calendar predictor and the queue of date results still owed by the core.
  class date_scoreboard;
    date_rsp_t pending_dates[$];
    int        mismatches;

    function bit leap_year(int y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int month_days(int y, int m);
      if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
      return 31;
    endfunction

    // Years are pinned to the supported span; a bad month or day falls back to the first.
    function void clamp_date(input int y, input int m, input int d,
                             output int cy, output int cm, output int cd);
      cy = y;
      if (cy < FIRST_YEAR) cy = FIRST_YEAR;
      if (cy > LAST_YEAR) cy = LAST_YEAR;
      cm = (m < MONTH_JAN || m > MONTH_DEC) ? int'(MONTH_JAN) : m;
      cd = (d < 1 || d > month_days(cy, cm)) ? 1 : d;
    endfunction

    // Zero-based count of days since the first supported day.
    function int day_index(int y, int m, int d);
      int n;
      n = 0;
      for (int i = FIRST_YEAR; i < y; i++) n += leap_year(i) ? 366 : 365;
      for (int i = MONTH_JAN; i < m; i++) n += month_days(y, i);
      return n + d - 1;
    endfunction

    function date_rsp_t predict_date(date_req_t r);
      date_rsp_t res;
      int ya, ma, da, yb, mb, db;
      int n, last_day, y, m;
      res = '0;
      clamp_date(r.year_a, r.month_a, r.day_a, ya, ma, da);
      clamp_date(r.year_b, r.month_b, r.day_b, yb, mb, db);
      if (r.cmd == CMD_DIFF) begin
        res.diff_days = DIFF_W'(day_index(ya, ma, da) - day_index(yb, mb, db));
        res.out_year  = YEAR_W'(ya);
        res.out_month = MONTH_W'(ma);
        res.out_day   = DAY_W'(da);
      end else begin
        last_day = day_index(LAST_YEAR, MONTH_DEC, 31);
        n = day_index(ya, ma, da) + int'(r.add_count);
        if (n > last_day) begin
          n = last_day;
          res.overflow = 1'b1;
        end
        // Split the day index back into year, month and day.
        y = FIRST_YEAR;
        while (n >= (leap_year(y) ? 366 : 365)) begin
          n -= leap_year(y) ? 366 : 365;
          y++;
        end
        m = MONTH_JAN;
        while (m < MONTH_DEC && n >= month_days(y, m)) begin
          n -= month_days(y, m);
          m++;
        end
        res.out_year  = YEAR_W'(y);
        res.out_month = MONTH_W'(m);
        res.out_day   = DAY_W'(n + 1);
      end
      return res;
    endfunction

    function void note_request(date_req_t r);
      pending_dates.push_back(predict_date(r));
    endfunction

    function void check_response(date_rsp_t got);
      date_rsp_t want;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result diff=%0d date=%0d-%0d-%0d ovf=%0b",
                   got.diff_days, got.out_year, got.out_month, got.out_day, got.overflow);
        return;
      end
      want = pending_dates.pop_front();
      if (got.diff_days !== want.diff_days || got.out_year !== want.out_year ||
          got.out_month !== want.out_month || got.out_day !== want.out_day ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: expected diff=%0d date=%0d-%0d-%0d ovf=%0b, got diff=%0d date=%0d-%0d-%0d ovf=%0b",
                   want.diff_days, want.out_year, want.out_month, want.out_day, want.overflow,
                   got.diff_days, got.out_year, got.out_month, got.out_day, got.overflow);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dca_req_if req_if ();
  dca_rsp_if rsp_if ();

  date_scoreboard dates = new;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit pressure_on  = 1'b0;
  bit hold_used    = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  calendar_date_arithmetic_core #(
    .YEAR_SPAN(YEAR_SPAN)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  function automatic date_req_t date_request(logic cmd, int ya, int ma, int da,
                                             int yb, int mb, int db, int cnt);
    date_request = '{cmd, YEAR_W'(ya), MONTH_W'(ma), DAY_W'(da),
                     YEAR_W'(yb), MONTH_W'(mb), DAY_W'(db), COUNT_W'(cnt)};
  endfunction

  // Mostly valid years inside the span, with early, late and boundary years mixed in.
  function automatic int random_year();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return $urandom_range(0, FIRST_YEAR - 1);
    if (pick < 12) return $urandom_range(LAST_YEAR + 1, (1 << YEAR_W) - 1);
    if (pick < 20) begin
      case ($urandom_range(0, 3))
        0: return FIRST_YEAR;
        1: return 2100;
        2: return LAST_YEAR;
        default: return 2096 + $urandom_range(0, 8);
      endcase
    end
    return $urandom_range(FIRST_YEAR, LAST_YEAR);
  endfunction

  function automatic int random_month();
    if ($urandom_range(0, 99) < 88) return $urandom_range(MONTH_JAN, MONTH_DEC);
    return $urandom_range(0, (1 << MONTH_W) - 1);
  endfunction

  function automatic int random_day();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 28);
    if (pick < 92) return $urandom_range(28, 31);
    return $urandom_range(0, (1 << DAY_W) - 1);
  endfunction

  function automatic int random_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return $urandom_range(0, 400);
    if (pick < 60) return $urandom_range(0, 10000);
    if (pick < 88) return $urandom_range(0, (1 << COUNT_W) - 1);
    return (1 << COUNT_W) - 1 - $urandom_range(0, 100);
  endfunction

  function automatic date_req_t random_request();
    logic cmd;
    cmd = $urandom_range(0, 1) ? CMD_ADD : CMD_DIFF;
    return date_request(cmd, random_year(), random_month(), random_day(),
                        random_year(), random_month(), random_day(), random_count());
  endfunction

  // Offer one request beat, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_request(date_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= r.cmd;
    req_if.year_a    <= r.year_a;
    req_if.month_a   <= r.month_a;
    req_if.day_a     <= r.day_a;
    req_if.year_b    <= r.year_b;
    req_if.month_b   <= r.month_b;
    req_if.day_b     <= r.day_b;
    req_if.add_count <= r.add_count;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    dates.note_request(r);
  endtask

  // Result ready: one long hold-off when pressure starts, otherwise random stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pressure_on && !hold_used) begin
        hold_used = 1'b1;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Check every accepted result beat.
  always @(posedge clk_i) begin : collect
    date_rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.diff_days = rsp_if.diff_days;
      got.out_year  = rsp_if.out_year;
      got.out_month = rsp_if.out_month;
      got.out_day   = rsp_if.out_day;
      got.overflow  = rsp_if.overflow;
      dates.check_response(got);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    date_req_t directed[$];
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_DIFF;
    req_if.year_a    = '0;
    req_if.month_a   = '0;
    req_if.day_a     = '0;
    req_if.year_b    = '0;
    req_if.month_b   = '0;
    req_if.day_b     = '0;
    req_if.add_count = '0;
    rsp_if.ready     = 1'b0;

    // Span ends, clamping of early and late years, bad months and days, leap rules.
    directed.push_back(date_request(CMD_DIFF, 2000, 1, 1, 2000, 1, 1, 0));
    directed.push_back(date_request(CMD_DIFF, LAST_YEAR, 12, 31, 2000, 1, 1, 0));
    directed.push_back(date_request(CMD_DIFF, 2000, 1, 1, LAST_YEAR, 12, 31, 65535));
    directed.push_back(date_request(CMD_DIFF, 0, 0, 0, 4095, 15, 31, 0));
    directed.push_back(date_request(CMD_DIFF, 2100, 2, 29, 2000, 2, 29, 0));
    directed.push_back(date_request(CMD_DIFF, 2004, 2, 30, 2003, 4, 31, 0));
    directed.push_back(date_request(CMD_DIFF, 2004, 13, 15, 2004, 3, 1, 0));
    directed.push_back(date_request(CMD_DIFF, LAST_YEAR, 12, 30, LAST_YEAR, 12, 31, 0));
    directed.push_back(date_request(CMD_DIFF, 1999, 12, 31, 2400, 2, 29, 0));
    directed.push_back(date_request(CMD_ADD, 2000, 1, 1, 0, 0, 0, 0));
    directed.push_back(date_request(CMD_ADD, 2000, 1, 1, 4095, 15, 31, 65535));
    directed.push_back(date_request(CMD_ADD, LAST_YEAR, 12, 31, 2000, 1, 1, 1));
    directed.push_back(date_request(CMD_ADD, LAST_YEAR, 12, 31, 2000, 1, 1, 0));
    directed.push_back(date_request(CMD_ADD, 2200, 1, 1, 2000, 1, 1, 65535));
    directed.push_back(date_request(CMD_ADD, 2000, 2, 28, 2000, 1, 1, 1));
    directed.push_back(date_request(CMD_ADD, 2100, 2, 28, 2000, 1, 1, 1));
    directed.push_back(date_request(CMD_ADD, 1999, 0, 0, 2000, 1, 1, 59));
    directed.push_back(date_request(CMD_ADD, 2099, 12, 31, 2000, 1, 1, 1));
    directed.push_back(date_request(CMD_ADD, 4095, 15, 31, 2000, 1, 1, 65535));
    directed.push_back(date_request(CMD_ADD, 2003, 12, 31, 2000, 1, 1, 366));
    directed.push_back(date_request(CMD_ADD, 2023, 6, 31, 2000, 1, 1, 30));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);

    // Random phases; the first one opens with a long result hold-off.
    pressure_on = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase
      repeat (RANDOM_PER_PHASE) send_request(random_request());
    end
    req_if.valid <= 1'b0;

    // Drain outstanding results, then watch for stray ones.
    while (dates.pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (dates.mismatches == 0 && dates.pending_dates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
